/* src/pvd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvd_pkg
// Shared types and constants for the prefix-length varint decoder.
// ----------------------------------------------------------------------------
package pvd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned LenW   = 4;
  localparam int unsigned RemW   = 3;
  localparam int unsigned ModeW  = 5;

  // Output tdata: value, length_bytes, zero fill up to whole bytes
  localparam int unsigned OutDataW = ((ValueW + LenW + 7) / 8) * 8;

  // Upper bounds of the prefix ranges, and single codes for the longer forms (top five bits of the first byte)
  localparam logic [ModeW-1:0] ModeOneMax   = 5'd15;
  localparam logic [ModeW-1:0] ModeTwoMax   = 5'd23;
  localparam logic [ModeW-1:0] ModeThreeMax = 5'd27;
  localparam logic [ModeW-1:0] ModeFour     = 5'd28;
  localparam logic [ModeW-1:0] ModeFive     = 5'd29;
  localparam logic [ModeW-1:0] ModeEight    = 5'd30;

  // One decoded result
  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] value;
    logic [LenW-1:0]   length_bytes;
    logic              bad_prefix;
  } result_t;

endpackage

/* src/pvd_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvd_decoder
// Per-byte decode state: gathers payload bytes and flags a finished integer.
// ----------------------------------------------------------------------------
module pvd_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [pvd_pkg::ByteW-1:0] byte_i,
  output pvd_pkg::result_t          result_o
);
  import pvd_pkg::*;

  logic [ValueW-1:0] partial_q, partial_d;
  logic [RemW-1:0]   remain_q, remain_d;
  logic [LenW-1:0]   total_q, total_d;
  logic [ModeW-1:0]  mode;
  logic [ValueW-1:0] shifted;

  assign mode    = byte_i[ByteW-1:ByteW-ModeW];
  assign shifted = {partial_q[ValueW-ByteW-1:0], byte_i};

  // Next state and result for the byte on the input
  always_comb begin
    partial_d = partial_q;
    remain_d  = remain_q;
    total_d   = total_q;
    result_o  = '0;
    if (accept_i) begin
      if (remain_q == '0) begin
        // first byte of an integer: the prefix picks length and mask
        if (mode <= ModeOneMax) begin
          result_o.valid        = 1'b1;
          result_o.value        = {{(ValueW-7){1'b0}}, byte_i[6:0]};
          result_o.length_bytes = LenW'(1);
        end else if (mode <= ModeTwoMax) begin
          partial_d = {{(ValueW-6){1'b0}}, byte_i[5:0]};
          remain_d  = RemW'(1);
          total_d   = LenW'(2);
        end else if (mode <= ModeThreeMax) begin
          partial_d = {{(ValueW-5){1'b0}}, byte_i[4:0]};
          remain_d  = RemW'(2);
          total_d   = LenW'(3);
        end else if (mode == ModeFour) begin
          partial_d = {{(ValueW-3){1'b0}}, byte_i[2:0]};
          remain_d  = RemW'(3);
          total_d   = LenW'(4);
        end else if (mode == ModeFive) begin
          partial_d = {{(ValueW-3){1'b0}}, byte_i[2:0]};
          remain_d  = RemW'(4);
          total_d   = LenW'(5);
        end else if (mode == ModeEight) begin
          partial_d = {{(ValueW-3){1'b0}}, byte_i[2:0]};
          remain_d  = RemW'(7);
          total_d   = LenW'(8);
        end else begin
          // all-ones prefix: byte consumed, bad result at once
          result_o.valid        = 1'b1;
          result_o.length_bytes = LenW'(1);
          result_o.bad_prefix   = 1'b1;
        end
      end else begin
        // continuation byte; bits above 31 fall off the top
        remain_d = remain_q - RemW'(1);
        if (remain_q == RemW'(1)) begin
          result_o.valid        = 1'b1;
          result_o.value        = shifted;
          result_o.length_bytes = total_q;
          partial_d             = '0;
          total_d               = '0;
        end else begin
          partial_d = shifted;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      remain_q  <= '0;
      total_q   <= '0;
    end else begin
      partial_q <= partial_d;
      remain_q  <= remain_d;
      total_q   <= total_d;
    end
  end

endmodule

/* src/prefix_varint32_decoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_varint32_decoder_top
// Stream decoder for big-endian prefix-length varints, 32-bit results.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while s_axis_tready is high, and the
// decode for a byte finishes in the cycle it is accepted. Results go through
// an output register backed by a one-entry skid register, which takes a
// result while the output register is held, so s_axis_tready only drops
// when two finished results are both waiting on the master side.
module prefix_varint32_decoder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] data_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [31:0] value, [35:32] length_bytes, [39:36] zero
  output logic [pvd_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tuser    // [0] bad_prefix
);
  import pvd_pkg::*;

  logic    in_accept;
  logic    out_pop;
  result_t res;
  result_t out_q, skid_q;

  assign s_axis_tready = !skid_q.valid;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_pop       = out_q.valid && m_axis_tready;

  pvd_decoder u_decoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (s_axis_tdata),
    .result_o (res)
  );

  // Output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q  <= '0;
      skid_q <= '0;
    end else begin
      if (!out_q.valid || out_pop) begin
        if (skid_q.valid) begin
          out_q        <= skid_q;
          skid_q.valid <= 1'b0;
        end else begin
          out_q <= res;
        end
      end else if (res.valid) begin
        skid_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_q.valid;
  assign m_axis_tdata  = {{(OutDataW-ValueW-LenW){1'b0}}, out_q.length_bytes, out_q.value};
  assign m_axis_tuser  = out_q.bad_prefix;

endmodule

/* src/pvd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvd_checker
// Port-level checks for the varint decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pvd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [pvd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tuser
);
  import pvd_pkg::*;

  // Stalled result holds its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

  // Length is always 1 to 8
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[35:32] != 4'd0 && m_axis_tdata[35:32] <= 4'd8))
    else $error("length out of range");

  // Bad prefix carries value zero and length one
  a_bad_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[35:32] == 4'd1))
    else $error("malformed bad-prefix result");

  // Input only stalls after the output was stalled
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

endmodule

bind prefix_varint32_decoder_top pvd_checker u_pvd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* bench/prefix_varint32_decoder_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_varint32_decoder_top_tb
// Self-checking bench for the prefix-length varint stream decoder.
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes (length extremes, bad prefixes, payload
// truncation) runs first, then a long stream of mostly well-formed varints
// with random payloads mixed with bad prefixes and loose bytes. Every accepted
// byte goes through a bit-accurate decoder model; decoded transactions on the
// master side are compared in order against the model's queue.
// ----------------------------------------------------------------------------
module prefix_varint32_decoder_top_tb;
  import pvd_pkg::*;

  localparam int unsigned ClkPeriod  = 12;
  localparam int unsigned NumRandom  = 1600;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned DrainWait  = 20;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned NumDirect  = 26;

  // One decoded integer as seen on the master side
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [LenW-1:0]   len;
    logic              bad;
  } varint_t;

  // One row of the directed table; fixed rows carry a hand-written result
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             fixed;
    varint_t          want;
  } byte_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  // Decoder model state
  logic [ValueW-1:0] acc_value;
  logic [RemW-1:0]   rem_bytes;
  logic [LenW-1:0]   int_len;

  varint_t decoded_q[$];
  int      errors;
  int      bytes_sent;
  int      results_seen;
  int      hold_left;
  bit      hold_done;
  bit      quiet;
  int      stall_cycles;

  byte_row_t direct_tab [NumDirect] = '{
    '{8'h00, 1'b1, '{32'h0000_0000, 4'd1, 1'b0}},
    '{8'h7F, 1'b1, '{32'h0000_007F, 4'd1, 1'b0}},
    '{8'hF8, 1'b1, '{32'h0000_0000, 4'd1, 1'b1}},
    '{8'hFF, 1'b1, '{32'h0000_0000, 4'd1, 1'b1}},
    '{8'hBF, 1'b0, '{32'h0, 4'd0, 1'b0}},
    '{8'hFF, 1'b1, '{32'h0000_3FFF, 4'd2, 1'b0}},
    '{8'hC0, 1'b0, '{32'h0, 4'd0, 1'b0}},
    '{8'h00, 1'b0, '{32'h0, 4'd0, 1'b0}},
    '{8'h01, 1'b1, '{32'h0000_0001, 4'd3, 1'b0}},
    '{8'hE0, 1'b0, '{32'h0, 4'd0, 1'b0}},
    '{8'h12, 1'b0, '{32'h0, 4'd0, 1'b0}},
    '{8'h34, 1'b0, '{32'h0, 4'd0, 1'b0}},
    '{8'h56, 1'b1, '{32'h0012_3456, 4'd4, 1'b0}},
    '{8'hE8, 1'b0, '{32'h0, 4'd0, 1'b0}},
    '{8'h01, 1'b0, '{32'h0, 4'd0, 1'b0}},
    '{8'h02, 1'b0, '{32'h0, 4'd0, 1'b0}},
    '{8'h03, 1'b0, '{32'h0, 4'd0, 1'b0}},
    '{8'h04, 1'b1, '{32'h0102_0304, 4'd5, 1'b0}},
    '{8'hF7, 1'b0, '{32'h0, 4'd0, 1'b0}},
    '{8'hFF, 1'b0, '{32'h0, 4'd0, 1'b0}},
    '{8'hFF, 1'b0, '{32'h0, 4'd0, 1'b0}},
    '{8'hFF, 1'b0, '{32'h0, 4'd0, 1'b0}},
    '{8'hFF, 1'b0, '{32'h0, 4'd0, 1'b0}},
    '{8'hFF, 1'b0, '{32'h0, 4'd0, 1'b0}},
    '{8'hFF, 1'b0, '{32'h0, 4'd0, 1'b0}},
    '{8'hFF, 1'b1, '{32'hFFFF_FFFF, 4'd8, 1'b0}}
  };

  prefix_varint32_decoder_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Decode one byte into the model; returns 1 when an integer completes
  function automatic bit decode_byte(input logic [ByteW-1:0] b, output varint_t res);
    logic [ModeW-1:0] mode;
    mode = b[7:3];
    res  = '0;
    if (rem_bytes == '0) begin
      if (mode <= ModeOneMax) begin
        res = '{ValueW'(b & 8'h7F), LenW'(1), 1'b0};
        return 1'b1;
      end else if (mode <= ModeTwoMax) begin
        acc_value = ValueW'(b & 8'h3F);
        rem_bytes = RemW'(1);
      end else if (mode <= ModeThreeMax) begin
        acc_value = ValueW'(b & 8'h1F);
        rem_bytes = RemW'(2);
      end else if (mode == ModeFour) begin
        acc_value = ValueW'(b & 8'h07);
        rem_bytes = RemW'(3);
      end else if (mode == ModeFive) begin
        acc_value = ValueW'(b & 8'h07);
        rem_bytes = RemW'(4);
      end else if (mode == ModeEight) begin
        acc_value = ValueW'(b & 8'h07);
        rem_bytes = RemW'(7);
      end else begin
        // all-ones prefix: byte consumed, flagged at once
        res = '{'0, LenW'(1), 1'b1};
        return 1'b1;
      end
      int_len = LenW'(rem_bytes) + LenW'(1);
      return 1'b0;
    end
    // continuation byte; upper payload bits fall off the top
    acc_value = {acc_value[ValueW-9:0], b};
    rem_bytes = rem_bytes - RemW'(1);
    if (rem_bytes != '0) return 1'b0;
    res       = '{acc_value, int_len, 1'b0};
    acc_value = '0;
    int_len   = '0;
    return 1'b1;
  endfunction

  // Append one expected transaction to the queue
  function automatic void queue_result(input varint_t r);
    decoded_q = {decoded_q, r};
  endfunction

  // Offer one byte on the slave side and wait for its transaction
  task automatic send_byte(input logic [ByteW-1:0] b);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    quiet = (bytes_sent >= 1000 + NumDirect) && (bytes_sent < 1300 + NumDirect);
  endtask

  // Send a byte and queue what the model decodes from it, or the row's hand-written result for fixed rows
  task automatic feed_byte(input logic [ByteW-1:0] b, input bit fixed, input varint_t want);
    varint_t res;
    bit      done;
    send_byte(b);
    done = decode_byte(b, res);
    if (fixed) queue_result(want);
    else if (done) queue_result(res);
  endtask

  // Random byte with the extremes favored
  function automatic logic [ByteW-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return ByteW'($urandom_range(0, 255));
  endfunction

  // One random varint, or a bad prefix, or a stray byte
  task automatic feed_varint();
    int unsigned      r;
    int unsigned      nbytes;
    logic [ModeW-1:0] mode;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      feed_byte({5'b11111, 3'($urandom_range(0, 7))}, 1'b0, '0);
    end else if (r < 16) begin
      feed_byte(ByteW'($urandom_range(0, 255)), 1'b0, '0);
    end else begin
      case ($urandom_range(0, 5))
        0: begin mode = ModeW'($urandom_range(0, ModeOneMax));               nbytes = 1; end
        1: begin mode = ModeW'($urandom_range(ModeOneMax + 1, ModeTwoMax));   nbytes = 2; end
        2: begin mode = ModeW'($urandom_range(ModeTwoMax + 1, ModeThreeMax)); nbytes = 3; end
        3: begin mode = ModeFour;  nbytes = 4; end
        4: begin mode = ModeFive;  nbytes = 5; end
        default: begin mode = ModeEight; nbytes = 8; end
      endcase
      feed_byte({mode, 3'($urandom_range(0, 7))}, 1'b0, '0);
      for (int i = 1; i < nbytes; i++) feed_byte(pick_byte(), 1'b0, '0);
    end
  endtask

  // Master-side ready: random idling, one long hold-off, quiet stretch
  initial begin
    m_axis_tready = 1'b0;
    hold_left     = 0;
    hold_done     = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (!hold_done && results_seen >= 150) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    varint_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (decoded_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("unexpected result: value=%h len=%0d bad=%b",
                   m_axis_tdata[31:0], m_axis_tdata[35:32], m_axis_tuser);
      end else begin
        want = decoded_q.pop_front();
        if (m_axis_tdata[31:0] !== want.value || m_axis_tdata[35:32] !== want.len ||
            m_axis_tdata[39:36] !== 4'h0 || m_axis_tuser !== want.bad) begin
          errors++;
          if (errors <= MaxReports)
            $display("mismatch: exp value=%h len=%0d bad=%b got value=%h len=%0d bad=%b pad=%h",
                     want.value, want.len, want.bad, m_axis_tdata[31:0],
                     m_axis_tdata[35:32], m_axis_tuser, m_axis_tdata[39:36]);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("prefix_varint32_decoder_top_tb: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    acc_value     = '0;
    rem_bytes     = '0;
    int_len       = '0;
    errors        = 0;
    bytes_sent    = 0;
    results_seen  = 0;
    quiet         = 1'b0;
    stall_cycles  = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    for (int i = 0; i < NumDirect; i++)
      feed_byte(direct_tab[i].data, direct_tab[i].fixed, direct_tab[i].want);

    // Random stream, with one pause that lets the decoder drain
    while (bytes_sent < NumRandom + NumDirect) begin
      if (bytes_sent >= 800 && bytes_sent < 810) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(negedge clk_i);
        bytes_sent = 810;
      end
      feed_varint();
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (decoded_q.size() != 0) errors++;

    if (errors == 0) begin
      $display("prefix_varint32_decoder_top_tb: clean");
    end else begin
      $display("prefix_varint32_decoder_top_tb: errors");
    end
    $finish;
  end

endmodule
